// ===== hdl/mrf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mrf_pkg: shared types and constants for the Modbus RTU request framer
// Holds the word layouts of both channels, the queue status group, the
// byte slot codes of a frame and the CRC-16/MODBUS byte update.
// ----------------------------------------------------------------------------
package mrf_pkg;

  // Frame geometry
  localparam int BODY_LEN    = 6;
  localparam int FRAME_LEN   = 8;
  localparam int BYTE_W      = 8;
  localparam int BODY_W      = BODY_LEN * BYTE_W;
  localparam int QUEUE_DEPTH = 2;

  // CRC-16/MODBUS, reflected form
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Command codes
  localparam logic CMD_READ        = 1'b0;
  localparam logic CMD_CHANGE_ADDR = 1'b1;

  // Byte slot codes within a frame
  localparam logic [2:0] SLOT_FIRST_BODY = 3'd0;
  localparam logic [2:0] SLOT_LAST_BODY  = 3'd5;
  localparam logic [2:0] SLOT_CRC_LO     = 3'd6;
  localparam logic [2:0] SLOT_CRC_HI     = 3'd7;

  typedef struct packed {
    logic              command;
    logic [7:0]        target_address;
    logic [7:0]        new_address;
    logic [BODY_W-1:0] request_body;
  } in_item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } out_item_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } q_status_t;

  // Fold one byte into the running CRC, one polynomial step per bit
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] crc;
    crc = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CRC_POLY;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/mrf_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mrf_front: request intake
// Takes a request word when the queue has room and patches the template:
// byte 0 becomes the target address, byte 5 the new address on a change.
// ----------------------------------------------------------------------------
module mrf_front (
  input  wire                        start,
  output logic                       busy,
  input  mrf_pkg::in_item_t          in_item,
  input  mrf_pkg::q_status_t         q_status,
  output logic                       push,
  output logic [mrf_pkg::BODY_W-1:0] push_body
);

  localparam int BW = mrf_pkg::BYTE_W;

  // Hold off new words while the queue is full
  assign busy = q_status.full;
  assign push = start && !q_status.full;

  // Patch the address bytes into the template
  always_comb begin
    push_body = in_item.request_body;
    push_body[BW-1:0] = in_item.target_address;
    if (in_item.command == mrf_pkg::CMD_CHANGE_ADDR) begin
      push_body[mrf_pkg::BODY_W-1 -: BW] = in_item.new_address;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/mrf_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mrf_queue: short body queue
// Circular buffer of patched frame bodies between intake and serialiser.
// ----------------------------------------------------------------------------
module mrf_queue #(
  parameter int DEPTH = mrf_pkg::QUEUE_DEPTH
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        push,
  input  wire [mrf_pkg::BODY_W-1:0]  push_body,
  input  wire                        pop,
  output logic [mrf_pkg::BODY_W-1:0] pop_body,
  output mrf_pkg::q_status_t         q_status
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [mrf_pkg::BODY_W-1:0] data_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign q_status.full      = (count_r == FULL_CNT);
  assign q_status.not_empty = (count_r != '0);
  assign do_push  = push && !q_status.full;
  assign do_pop   = pop && q_status.not_empty;
  assign pop_body = data_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the incoming body
  always_ff @(posedge clk) begin
    if (do_push) begin
      data_r[wr_ptr_r] <= push_body;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/mrf_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mrf_back: frame serialiser
// Sends one byte a cycle: six body bytes, then CRC low and high, folding
// each body byte into the CRC as it goes out. Reloads without a gap.
// ----------------------------------------------------------------------------
module mrf_back (
  input  wire                        clk,
  input  wire                        rst_n,
  input  mrf_pkg::q_status_t         q_status,
  input  wire [mrf_pkg::BODY_W-1:0]  pop_body,
  output logic                       pop,
  output logic                       out_valid,
  output mrf_pkg::out_item_t         out_item
);

  localparam int BW = mrf_pkg::BYTE_W;

  logic                       active_r, active_nxt;
  logic [2:0]                 slot_r, slot_nxt;
  logic [mrf_pkg::BODY_W-1:0] body_r, body_nxt;
  logic [15:0]                crc_r, crc_nxt;
  logic                       valid_r, valid_nxt;
  mrf_pkg::out_item_t         item_r, item_nxt;

  // Take the next body when idle or on the final byte of a frame
  assign pop = q_status.not_empty &&
               (!active_r || (slot_r == mrf_pkg::SLOT_CRC_HI));

  always_comb begin
    active_nxt = active_r;
    slot_nxt   = slot_r;
    body_nxt   = body_r;
    crc_nxt    = crc_r;
    valid_nxt  = 1'b0;
    item_nxt   = item_r;
    if (active_r) begin
      valid_nxt          = 1'b1;
      item_nxt.last_byte = (slot_r == mrf_pkg::SLOT_CRC_HI);
      slot_nxt           = slot_r + 1'b1;
      case (slot_r) inside
        [mrf_pkg::SLOT_FIRST_BODY:mrf_pkg::SLOT_LAST_BODY]: begin
          item_nxt.frame_byte = body_r[BW-1:0];
          crc_nxt             = mrf_pkg::crc_byte(crc_r, body_r[BW-1:0]);
          body_nxt            = body_r >> BW;
        end
        mrf_pkg::SLOT_CRC_LO: begin
          item_nxt.frame_byte = crc_r[7:0];
        end
        mrf_pkg::SLOT_CRC_HI: begin
          item_nxt.frame_byte = crc_r[15:8];
          active_nxt          = 1'b0;
        end
        default: begin
          item_nxt.frame_byte = '0;
        end
      endcase
    end
    // Load a fresh body
    if (pop) begin
      active_nxt = 1'b1;
      slot_nxt   = mrf_pkg::SLOT_FIRST_BODY;
      body_nxt   = pop_body;
      crc_nxt    = mrf_pkg::CRC_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      slot_r   <= mrf_pkg::SLOT_FIRST_BODY;
      valid_r  <= 1'b0;
    end else begin
      active_r <= active_nxt;
      slot_r   <= slot_nxt;
      valid_r  <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    body_r <= body_nxt;
    crc_r  <= crc_nxt;
    item_r <= item_nxt;
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule
`default_nettype wire

// ===== hdl/modbus_rtu_request_framer_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// modbus_rtu_request_framer_unit: Modbus RTU request framer
// A taken word passes the queue, the serialiser load and the output register.
// Throughput: one byte a cycle while a frame goes out, set by the serialiser.
// A short queue takes the next word while a frame is still going out.
// busy is high only while the queue is full; results cannot be stalled.
// Reset (synchronous, rst_n low) empties the queue and stops the serialiser.
// ----------------------------------------------------------------------------
module modbus_rtu_request_framer_unit #(
  parameter int QUEUE_DEPTH = mrf_pkg::QUEUE_DEPTH
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  output logic               busy,
  input  mrf_pkg::in_item_t  in_item,
  output logic               out_valid,
  output mrf_pkg::out_item_t out_item
);

  mrf_pkg::q_status_t         q_status;
  logic                       push, pop;
  logic [mrf_pkg::BODY_W-1:0] push_body, pop_body;

  mrf_front u_front (
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .q_status  (q_status),
    .push      (push),
    .push_body (push_body)
  );

  mrf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_body (push_body),
    .pop       (pop),
    .pop_body  (pop_body),
    .q_status  (q_status)
  );

  mrf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_status  (q_status),
    .pop_body  (pop_body),
    .pop       (pop),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

`ifndef SYNTH
  // Never push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_status.full)
    else $error("push into full queue");

  // Never pop an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_status.not_empty)
    else $error("pop from empty queue");

  // Two last-byte strobes never come back to back
  a_last_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.last_byte) |=> !(out_valid && out_item.last_byte))
    else $error("back-to-back last bytes");
`endif

endmodule
`default_nettype wire
